[rtl/core/rcmf_pkg.sv]
// ----------------------------------------------------------------------------
// rcmf_pkg
// shared constants, command codes and types of the rotation consistency
// match filter
// ----------------------------------------------------------------------------
`default_nettype none

package rcmf_pkg;

    localparam int HIST_BINS   = 60;
    localparam int MAX_MATCHES = 1024;
    localparam int INDEX_BITS  = 12;

    localparam int OP_W    = 2;
    localparam int DIST_W  = 9;
    localparam int ANGLE_W = 15;

    localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(50);

    // one full turn in 1/64 degree
    localparam int ANGLE_FULL = 23040;
    localparam int WRAP_W     = ANGLE_W + 2;

    localparam int BIN_W   = $clog2(HIST_BINS);
    localparam int BINC_W  = $clog2(HIST_BINS + 1);
    localparam int ADDR_W  = $clog2(MAX_MATCHES);
    localparam int CNT_W   = $clog2(MAX_MATCHES + 1);
    localparam int ENTRY_W = 2 * INDEX_BITS + BIN_W;

    // bin = (d * HIST_BINS + ANGLE_FULL / 2) / ANGLE_FULL
    // ANGLE_FULL = 512 * 45: shift by 9, then reciprocal of 45
    localparam int SCALED_W = $clog2((ANGLE_FULL - 1) * HIST_BINS + ANGLE_FULL / 2 + 1);
    localparam int PRE_SH   = 9;
    localparam int DIV_REST = ANGLE_FULL / 512;
    localparam int RECIP_SH = 20;
    localparam int RECIP    = (2 ** RECIP_SH + DIV_REST - 1) / DIV_REST;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int M_W      = SCALED_W - PRE_SH;
    localparam int PROD_W   = M_W + RECIP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [INDEX_BITS-1:0] query;
        logic [INDEX_BITS-1:0] train;
        logic [ANGLE_W-1:0]    diff;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

[rtl/core/rcmf_ram.sv]
// ----------------------------------------------------------------------------
// rcmf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/rcmf_front.sv]
// ----------------------------------------------------------------------------
// rcmf_front
// command intake: distance limit register, drop of rejected and unused
// commands, angle difference wrapped into one turn
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [rcmf_pkg::OP_W-1:0]         i_operation,
    input  wire logic [rcmf_pkg::INDEX_BITS-1:0]   i_query_index,
    input  wire logic [rcmf_pkg::INDEX_BITS-1:0]   i_train_index,
    input  wire logic [rcmf_pkg::DIST_W-1:0]       i_match_distance,
    input  wire logic [rcmf_pkg::ANGLE_W-1:0]      i_ref_angle,
    input  wire logic [rcmf_pkg::ANGLE_W-1:0]      i_cur_angle,
    input  wire logic                              i_cfg_valid,
    input  wire logic [rcmf_pkg::DIST_W-1:0]       i_cfg_data,
    output logic                                   o_cfg_ready,
    input  wire rcmf_pkg::t_q_status               i_q_status,
    output logic                                   o_push,
    output rcmf_pkg::t_cmd                         o_cmd
);

    localparam int WW = rcmf_pkg::WRAP_W;
    localparam logic [WW-1:0] FULL1 = WW'(rcmf_pkg::ANGLE_FULL);
    localparam logic [WW-1:0] FULL2 = WW'(2 * rcmf_pkg::ANGLE_FULL);
    localparam logic [WW-1:0] FULL3 = WW'(3 * rcmf_pkg::ANGLE_FULL);

    logic [rcmf_pkg::DIST_W-1:0] r_dist_limit;
    logic                        accept;
    logic                        keep;
    logic [WW-1:0]               raw_diff;
    logic [WW-1:0]               wrapped;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_limit <= rcmf_pkg::DIST_RESET;
        end else if (i_cfg_valid) begin
            r_dist_limit <= i_cfg_data;
        end
    end

    assign accept = i_start && !i_q_status.full && i_rst_n;

    always_comb begin
        unique case (i_operation)
            rcmf_pkg::OP_CLEAR:  keep = 1'b1;
            rcmf_pkg::OP_INSERT: keep = (i_match_distance <= r_dist_limit);
            rcmf_pkg::OP_FETCH:  keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    // ref - cur plus two turns, always positive, below four turns
    assign raw_diff = {2'b00, i_ref_angle} + FULL2 - {2'b00, i_cur_angle};

    always_comb begin
        if (raw_diff >= FULL3) begin
            wrapped = raw_diff - FULL3;
        end else if (raw_diff >= FULL2) begin
            wrapped = raw_diff - FULL2;
        end else if (raw_diff >= FULL1) begin
            wrapped = raw_diff - FULL1;
        end else begin
            wrapped = raw_diff;
        end
    end

    assign o_push      = accept && keep;
    assign o_cmd.op    = i_operation;
    assign o_cmd.query = i_query_index;
    assign o_cmd.train = i_train_index;
    assign o_cmd.diff  = wrapped[rcmf_pkg::ANGLE_W-1:0];

endmodule

`default_nettype wire

[rtl/core/rcmf_queue.sv]
// ----------------------------------------------------------------------------
// rcmf_queue
// short command queue between intake and execution
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rcmf_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output rcmf_pkg::t_cmd       o_head,
    output rcmf_pkg::t_q_status  o_status
);

    localparam int PW = rcmf_pkg::QPTR_W;
    localparam int CW = rcmf_pkg::QCNT_W;

    rcmf_pkg::t_cmd r_slot [rcmf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(rcmf_pkg::QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/rcmf_back.sv]
// ----------------------------------------------------------------------------
// rcmf_back
// command execution: match store, bin histogram, winner search, fetch scan
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rcmf_pkg::t_q_status             i_q_status,
    input  wire rcmf_pkg::t_cmd                  i_head,
    output logic                                 o_pop,
    output logic                                 o_strobe,
    output logic                                 o_found,
    output logic [rcmf_pkg::INDEX_BITS-1:0]      o_kept_query_index,
    output logic [rcmf_pkg::INDEX_BITS-1:0]      o_kept_train_index,
    output logic                                 o_last_kept,
    output logic                                 o_overflowed
);

    localparam int IB  = rcmf_pkg::INDEX_BITS;
    localparam int BW  = rcmf_pkg::BIN_W;
    localparam int CW  = rcmf_pkg::CNT_W;
    localparam int AW  = rcmf_pkg::ADDR_W;
    localparam int SW  = rcmf_pkg::SCALED_W;
    localparam int PW  = rcmf_pkg::PROD_W;
    localparam int HB  = rcmf_pkg::HIST_BINS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_A    = 4'd1;
    localparam logic [3:0] S_INS_B    = 4'd2;
    localparam logic [3:0] S_INS_C    = 4'd3;
    localparam logic [3:0] S_INS_D    = 4'd4;
    localparam logic [3:0] S_ARG_RD   = 4'd5;
    localparam logic [3:0] S_ARG_CMP  = 4'd6;
    localparam logic [3:0] S_SCAN_RD  = 4'd7;
    localparam logic [3:0] S_SCAN_CHK = 4'd8;

    logic [3:0]                   r_state;
    logic [3:0]                   n_state;
    logic [CW-1:0]                r_stored;
    logic [CW-1:0]                r_cursor;
    logic [CW-1:0]                r_emitted;
    logic [CW-1:0]                r_win_count;
    logic [BW-1:0]                r_win_bin;
    logic                         r_win_valid;
    logic                         r_overflow;
    logic [HB-1:0]                r_valid;
    logic [BW-1:0]                r_scan;
    logic [BW-1:0]                r_best;
    logic [CW-1:0]                r_best_n;
    logic [IB-1:0]                r_query;
    logic [IB-1:0]                r_train;
    logic [rcmf_pkg::ANGLE_W-1:0] r_diff;
    logic [SW-1:0]                r_scaled;
    logic [PW-1:0]                r_prod;
    logic [BW-1:0]                r_bin;
    logic                         r_strobe;
    logic                         r_found;
    logic [IB-1:0]                r_kq;
    logic [IB-1:0]                r_kt;
    logic                         r_last;

    logic [PW-rcmf_pkg::RECIP_SH-1:0] quot;
    logic [rcmf_pkg::BINC_W-1:0]      bin_c;
    logic [BW-1:0]                    bin_now;
    logic [BW-1:0]                    cnt_raddr;
    logic [CW-1:0]                    cnt_rdata;
    logic [BW-1:0]                    sel_bin;
    logic [CW-1:0]                    cnt_eff;
    logic [rcmf_pkg::ENTRY_W-1:0]     m_rdata;
    logic [BW-1:0]                    m_bin;
    logic [IB-1:0]                    m_train;
    logic [IB-1:0]                    m_query;
    logic                             better;
    logic [BW-1:0]                    cand_best;
    logic [CW-1:0]                    cand_n;
    logic                             scan_hit;
    logic                             scan_end;

    // bin from the reciprocal product, top bin folds to zero
    assign quot    = r_prod[PW-1:rcmf_pkg::RECIP_SH];
    assign bin_c   = rcmf_pkg::BINC_W'(quot);
    assign bin_now = (bin_c >= rcmf_pkg::BINC_W'(HB)) ? '0 : bin_c[BW-1:0];

    assign cnt_raddr = (r_state == S_ARG_RD) ? r_scan : bin_now;
    assign sel_bin   = (r_state == S_INS_D) ? r_bin : r_scan;
    assign cnt_eff   = r_valid[sel_bin] ? cnt_rdata : '0;

    assign better    = (cnt_eff > r_best_n);
    assign cand_best = better ? r_scan : r_best;
    assign cand_n    = better ? cnt_eff : r_best_n;

    assign m_bin   = m_rdata[BW-1:0];
    assign m_train = m_rdata[BW +: IB];
    assign m_query = m_rdata[BW+IB +: IB];

    // entry of the winning bin found, or read ran off the end of the store
    assign scan_hit = (r_state == S_SCAN_CHK) && (m_bin == r_win_bin);
    assign scan_end = (r_state == S_SCAN_RD) && (r_cursor >= r_stored);

    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;

    rcmf_ram #(
        .WIDTH (CW),
        .DEPTH (HB)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_INS_D),
        .i_waddr (r_bin),
        .i_wdata (cnt_eff + CW'(1)),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    rcmf_ram #(
        .WIDTH (rcmf_pkg::ENTRY_W),
        .DEPTH (rcmf_pkg::MAX_MATCHES)
    ) u_match_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_INS_C),
        .i_waddr (r_stored[AW-1:0]),
        .i_wdata ({r_query, r_train, bin_now}),
        .i_raddr (r_cursor[AW-1:0]),
        .o_rdata (m_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_head.op == rcmf_pkg::OP_INSERT &&
                        r_stored != CW'(rcmf_pkg::MAX_MATCHES)) begin
                        n_state = S_INS_A;
                    end else if (i_head.op == rcmf_pkg::OP_FETCH) begin
                        n_state = r_win_valid ? S_SCAN_RD : S_ARG_RD;
                    end
                end
            end
            S_INS_A:   n_state = S_INS_B;
            S_INS_B:   n_state = S_INS_C;
            S_INS_C:   n_state = S_INS_D;
            S_INS_D:   n_state = S_IDLE;
            S_ARG_RD:  n_state = S_ARG_CMP;
            S_ARG_CMP: begin
                n_state = (r_scan == BW'(HB - 1)) ? S_SCAN_RD : S_ARG_RD;
            end
            S_SCAN_RD: begin
                n_state = (r_cursor >= r_stored) ? S_IDLE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = (m_bin == r_win_bin) ? S_IDLE : S_SCAN_RD;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_query <= i_head.query;
            r_train <= i_head.train;
            r_diff  <= i_head.diff;
        end
        r_scaled <= SW'(r_diff) * SW'(HB) + SW'(rcmf_pkg::ANGLE_FULL / 2);
        r_prod   <= PW'(r_scaled[SW-1:rcmf_pkg::PRE_SH]) * PW'(rcmf_pkg::RECIP);
        if (r_state == S_INS_C) begin
            r_bin <= bin_now;
        end
        if (r_state == S_SCAN_CHK) begin
            r_kq <= m_query;
            r_kt <= m_train;
        end else begin
            r_kq <= '0;
            r_kt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stored    <= '0;
            r_cursor    <= '0;
            r_emitted   <= '0;
            r_win_count <= '0;
            r_win_bin   <= '0;
            r_win_valid <= 1'b0;
            r_overflow  <= 1'b0;
            r_valid     <= '0;
            r_scan      <= '0;
            r_best      <= '0;
            r_best_n    <= '0;
            r_strobe    <= 1'b0;
            r_found     <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= scan_hit || scan_end;
            r_found  <= scan_hit;
            r_last   <= scan_hit && (CW'(r_emitted + CW'(1)) == r_win_count);
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        if (i_head.op == rcmf_pkg::OP_CLEAR) begin
                            r_stored    <= '0;
                            r_cursor    <= '0;
                            r_emitted   <= '0;
                            r_win_bin   <= '0;
                            r_win_valid <= 1'b0;
                            r_overflow  <= 1'b0;
                            r_valid     <= '0;
                        end else if (i_head.op == rcmf_pkg::OP_INSERT &&
                                     r_stored == CW'(rcmf_pkg::MAX_MATCHES)) begin
                            r_overflow <= 1'b1;
                        end else if (i_head.op == rcmf_pkg::OP_FETCH && !r_win_valid) begin
                            r_scan   <= '0;
                            r_best   <= '0;
                            r_best_n <= '0;
                        end
                    end
                end
                S_INS_D: begin
                    r_valid[r_bin] <= 1'b1;
                    r_stored       <= r_stored + CW'(1);
                    r_win_valid    <= 1'b0;
                    r_cursor       <= '0;
                    r_emitted      <= '0;
                end
                S_ARG_CMP: begin
                    r_best   <= cand_best;
                    r_best_n <= cand_n;
                    r_scan   <= r_scan + BW'(1);
                    if (r_scan == BW'(HB - 1)) begin
                        r_win_bin   <= cand_best;
                        r_win_count <= cand_n;
                        r_win_valid <= 1'b1;
                        r_cursor    <= '0;
                        r_emitted   <= '0;
                    end
                end
                S_SCAN_CHK: begin
                    r_cursor <= r_cursor + CW'(1);
                    if (m_bin == r_win_bin) begin
                        r_emitted <= r_emitted + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe           = r_strobe;
    assign o_found            = r_found;
    assign o_kept_query_index = r_kq;
    assign o_kept_train_index = r_kt;
    assign o_last_kept        = r_last;
    assign o_overflowed       = r_overflow;

endmodule

`default_nettype wire

[rtl/core/rotation_consistency_match_filter.sv]
// ----------------------------------------------------------------------------
// rotation_consistency_match_filter
// keeps feature matches whose keypoint rotation agrees with the most common
// rotation of the set: clear, insert and fetch commands
// ----------------------------------------------------------------------------
//
// channel    direction  beat marked by               payload
// command    in         i_start high, o_busy low     operation, indices,
//                                                    distance, two angles
// config     in         i_cfg_valid and o_cfg_ready  distance limit (9 bit)
// result     out        o_strobe, one cycle          found, indices,
//                                                    last_kept, overflowed
//
// flow: inserts over the distance limit and the unused code are dropped at
//   intake; the rest wait in a two-deep queue, then the executor takes a
//   clear or a capacity-dropped insert in its idle state, a stored insert
//   through its insert states, a fetch by a read and a check per stored
//   entry scanned, an end read when none is left, and a bin ram winner
//   search on the first fetch after a change; the result strobe is registered
// reset: synchronous, active low; histogram bins carry valid flags so no
//   clearing pass is needed and commands are taken straight after reset
// stalls: o_busy is high while the queue is full or reset is held; results
//   cannot be held off and never come on consecutive cycles
//
`default_nettype none

module rotation_consistency_match_filter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command channel
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [rcmf_pkg::OP_W-1:0]       i_operation,
    input  wire logic [rcmf_pkg::INDEX_BITS-1:0] i_query_index,
    input  wire logic [rcmf_pkg::INDEX_BITS-1:0] i_train_index,
    input  wire logic [rcmf_pkg::DIST_W-1:0]     i_match_distance,
    input  wire logic [rcmf_pkg::ANGLE_W-1:0]    i_ref_angle,
    input  wire logic [rcmf_pkg::ANGLE_W-1:0]    i_cur_angle,
    // distance limit write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rcmf_pkg::DIST_W-1:0]     i_cfg_data,
    // results
    output logic                                 o_strobe,
    output logic                                 o_found,
    output logic [rcmf_pkg::INDEX_BITS-1:0]      o_kept_query_index,
    output logic [rcmf_pkg::INDEX_BITS-1:0]      o_kept_train_index,
    output logic                                 o_last_kept,
    output logic                                 o_overflowed
);

    rcmf_pkg::t_q_status q_status;
    rcmf_pkg::t_cmd      push_cmd;
    rcmf_pkg::t_cmd      head_cmd;
    logic                push;
    logic                pop;

    // no beats are taken while reset is held
    assign o_busy = q_status.full || !i_rst_n;

    // intake: limit check, unused code drop, angle wrap
    rcmf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_operation      (i_operation),
        .i_query_index    (i_query_index),
        .i_train_index    (i_train_index),
        .i_match_distance (i_match_distance),
        .i_ref_angle      (i_ref_angle),
        .i_cur_angle      (i_cur_angle),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_cfg_ready      (o_cfg_ready),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // decouples intake from the multi-cycle executor
    rcmf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // executor: store, histogram, winner search, fetch scan
    rcmf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_status         (q_status),
        .i_head             (head_cmd),
        .o_pop              (pop),
        .o_strobe           (o_strobe),
        .o_found            (o_found),
        .o_kept_query_index (o_kept_query_index),
        .o_kept_train_index (o_kept_train_index),
        .o_last_kept        (o_last_kept),
        .o_overflowed       (o_overflowed)
    );

endmodule

`default_nettype wire

[rtl/core/rcmf_checker.sv]
// ----------------------------------------------------------------------------
// rcmf_checker
// port level checks of the rotation consistency match filter
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_start,
    input wire logic                            o_busy,
    input wire logic                            o_strobe,
    input wire logic                            o_found,
    input wire logic [rcmf_pkg::INDEX_BITS-1:0] o_kept_query_index,
    input wire logic [rcmf_pkg::INDEX_BITS-1:0] o_kept_train_index,
    input wire logic                            o_last_kept
);

    // an empty fetch carries zero indices and no last flag
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_found |->
            o_kept_query_index == '0 && o_kept_train_index == '0 && !o_last_kept)
        else $error("empty result with non-zero payload");

    // each result sends the executor back to idle, so results never abut
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on consecutive cycles");

    // the queue only fills through an accepted command beat
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without a command beat");

endmodule

bind rotation_consistency_match_filter rcmf_checker u_rcmf_checker (.*);

`default_nettype wire
